// ===== rtl/cadj_pkg.sv =====
`timescale 1ns / 1ps
package cadj_pkg;

  // Gamma table geometry
  localparam int GammaTableDepth = 256;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgBrightness  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgContrast    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSaturation  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgGammaEnable = 2'd3;
  localparam int CfgDataW = 7;

  // Fixed-point widths (Q8 samples, Q16 factors)
  localparam int PixW  = 8;
  localparam int OffW  = 18;            // brightness offset minus midpoint, signed Q8
  localparam int FacW  = 18;            // contrast / saturation factor, unsigned Q16
  localparam int DW    = 19;            // pixel + offset - midpoint, signed Q8
  localparam int P1W   = DW + FacW + 1; // contrast product
  localparam int ChW   = 20;            // contrast-adjusted channel, signed Q8
  localparam int LumaW = ChW + 1;       // luma, signed Q8
  localparam int LPW   = ChW + 17;      // weighted channel product
  localparam int LSW   = LPW + 2;       // weighted sum
  localparam int DiffW = LumaW + 1;     // channel minus luma
  localparam int P2W   = DiffW + FacW + 1;
  localparam int XW    = P2W - 16 + 1;  // saturated channel before clamp

  // Pipeline depth from accept to the last lane register
  localparam int PipeStages = 8;

  localparam logic signed [OffW-1:0] OffmReset = -18'sd32640;
  localparam logic [FacW-1:0]        FacReset  = 18'd65536;
  localparam logic signed [16:0]     MidQ8     = 17'sd32640;
  localparam logic signed [16:0]     MaxQ8     = 17'sd65280;
  localparam logic signed [16:0]     HalfQ16   = 17'sd32768;
  localparam logic signed [16:0]     WRed      = 17'sd19595;
  localparam logic signed [16:0]     WGreen    = 17'sd38470;
  localparam logic signed [16:0]     WBlue     = 17'sd7471;

  // Write request to the gamma table copies
  typedef struct packed {
    logic            we;
    logic [PixW-1:0] addr;
    logic [PixW-1:0] data;
  } gamma_wr_t;

  // round(b * 1305.6) - 65280 - 32640, with /10 done by reciprocal
  function automatic logic signed [OffW-1:0] offm_from_setting(input logic [CfgDataW-1:0] b);
    logic [17:0]        base;
    logic [9:0]         m;
    logic [20:0]        mq;
    logic signed [18:0] sum;
    base = 18'(b) * 18'd1305;
    m    = 10'(b) * 10'd6 + 10'd5;
    mq   = 21'(m) * 21'd205;
    sum  = $signed({1'b0, base}) + $signed({12'd0, mq[17:11]}) - 19'sd97920;
    return sum[OffW-1:0];
  endfunction

  // round(v * 65536 / 50), with /100 done by reciprocal
  function automatic logic [FacW-1:0] factor_from_setting(input logic [CfgDataW-1:0] v);
    logic [17:0] base;
    logic [13:0] m;
    logic [26:0] mq;
    base = 18'(v) * 18'd1310;
    m    = 14'(v) * 14'd72 + 14'd50;
    mq   = 27'(m) * 27'd5243;
    return base + 18'(mq[25:19]);
  endfunction

endpackage

// ===== rtl/cadj_lane.sv =====
`timescale 1ns / 1ps
module cadj_lane
  import cadj_pkg::*;
(
  input  logic                    clk_i,
  input  logic [PixW-1:0]         pix_i,
  input  logic signed [OffW-1:0]  offm_i,
  input  logic [FacW-1:0]         cf_i,
  input  logic [FacW-1:0]         sf_i,
  input  logic signed [LumaW-1:0] luma_i,
  output logic signed [ChW-1:0]   ch_o,
  output logic [PixW-1:0]         val_o
);

  logic signed [DW-1:0]    d_q, d_d;
  logic signed [P1W-1:0]   p1_q, p1_d, t1;
  logic signed [ChW-1:0]   ch_q, ch_d, ch1_q, ch2_q;
  logic signed [DiffW-1:0] diff_q, diff_d;
  logic signed [LumaW-1:0] luma1_q, luma2_q;
  logic signed [P2W-1:0]   p2_q, p2_d, t2;
  logic signed [XW-1:0]    x;
  logic [15:0]             xc;
  logic [16:0]             xr;
  logic [PixW-1:0]         val_q, val_d;

  always_comb begin
    d_d    = $signed({3'b000, pix_i, 8'h00}) + DW'(offm_i);
    p1_d   = P1W'(d_q) * P1W'($signed({1'b0, cf_i}));
    t1     = p1_q + P1W'(HalfQ16);
    ch_d   = $signed(t1[16 +: ChW]) + ChW'(MidQ8);
    diff_d = DiffW'(ch2_q) - DiffW'(luma_i);
    p2_d   = P2W'(diff_q) * P2W'($signed({1'b0, sf_i}));
    t2     = p2_q + P2W'(HalfQ16);
    x      = XW'($signed(t2[P2W-1:16])) + XW'(luma2_q);
    if (x < 0) begin
      xc = 16'd0;
    end else if (x > XW'(MaxQ8)) begin
      xc = 16'(MaxQ8);
    end else begin
      xc = x[15:0];
    end
    xr    = 17'(xc) + 17'd128;
    val_d = xr[15:8];
  end

  always_ff @(posedge clk_i) begin
    d_q     <= d_d;
    p1_q    <= p1_d;
    ch_q    <= ch_d;
    ch1_q   <= ch_q;
    ch2_q   <= ch1_q;
    diff_q  <= diff_d;
    luma1_q <= luma_i;
    p2_q    <= p2_d;
    luma2_q <= luma1_q;
    val_q   <= val_d;
  end

  assign ch_o  = ch_q;
  assign val_o = val_q;

endmodule

// ===== rtl/cadj_luma.sv =====
`timescale 1ns / 1ps
module cadj_luma
  import cadj_pkg::*;
(
  input  logic                    clk_i,
  input  logic signed [ChW-1:0]   ch_r_i,
  input  logic signed [ChW-1:0]   ch_g_i,
  input  logic signed [ChW-1:0]   ch_b_i,
  output logic signed [LumaW-1:0] luma_o
);

  logic signed [LPW-1:0]   pr_q, pg_q, pb_q;
  logic signed [LSW-1:0]   sum;
  logic signed [LumaW-1:0] luma_q;

  always_comb begin
    sum = LSW'(pr_q) + LSW'(pg_q) + LSW'(pb_q) + LSW'(HalfQ16);
  end

  always_ff @(posedge clk_i) begin
    pr_q   <= LPW'(ch_r_i) * LPW'(WRed);
    pg_q   <= LPW'(ch_g_i) * LPW'(WGreen);
    pb_q   <= LPW'(ch_b_i) * LPW'(WBlue);
    luma_q <= sum[16 +: LumaW];
  end

  assign luma_o = luma_q;

endmodule

// ===== rtl/cadj_gamma.sv =====
`timescale 1ns / 1ps
module cadj_gamma
  import cadj_pkg::*;
#(
  parameter int Depth = GammaTableDepth
) (
  input  logic            clk_i,
  input  gamma_wr_t       wr_i,
  input  logic [PixW-1:0] val_i,
  input  logic            gamma_en_i,
  output logic [PixW-1:0] out_o
);

  localparam int AW = $clog2(Depth);

  logic [PixW-1:0] mem [Depth];
  logic [PixW-1:0] rd_q;
  logic [PixW-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
    rd_q  <= mem[val_i[AW-1:0]];
    val_q <= val_i;
  end

  assign out_o = gamma_en_i ? rd_q : val_q;

endmodule

// ===== rtl/pixel_color_adjust.sv =====
`timescale 1ns / 1ps
// Brightness / contrast / saturation / gamma adjust for one RGB pixel a clock.
//
// Command channel: a transaction is taken at every rising edge with start_i
// high; busy_o is always low, so a pixel or a table write can follow every
// cycle. op_i = 0 adjusts red/green/blue_in_i, op_i = 1 writes table_value_i
// into gamma entry table_index_i and gives no result.
// Result channel: done_o pulses for one cycle with red/green/blue_out_o, once
// the pixel has passed the lanes and the gamma read register. Results leave in
// order, one per clock at most; the receiver cannot stall (no backpressure path).
// Throughput is one item per cycle, set by the three channel lanes (contrast
// multiply, saturation multiply, clamp/round), the luma merge stage between
// them and one gamma table copy per lane, each read once a cycle.
// Table writes travel down the same pipeline and land at the table read stage,
// so each pixel sees exactly the writes taken before it.
// Config channel: cfg_ready_o is always high; a write is taken when
// cfg_valid_i is high. Write only while no pixel is in flight.
// Reset: settings return to neutral (50/50/50) and gamma off; the table is
// not cleared and must be loaded before gamma is enabled.
module pixel_color_adjust
  import cadj_pkg::*;
#(
  parameter int GAMMA_TABLE_DEPTH = GammaTableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                start_i,
  output logic                busy_o,
  input  logic                op_i,
  input  logic [PixW-1:0]     red_in_i,
  input  logic [PixW-1:0]     green_in_i,
  input  logic [PixW-1:0]     blue_in_i,
  input  logic [PixW-1:0]     table_index_i,
  input  logic [PixW-1:0]     table_value_i,
  // result channel
  output logic                done_o,
  output logic [PixW-1:0]     red_out_o,
  output logic [PixW-1:0]     green_out_o,
  output logic [PixW-1:0]     blue_out_o,
  // configuration channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Settings are held in their fixed-point form, converted on write.
  logic signed [OffW-1:0] offm_q;
  logic [FacW-1:0]        cf_q;
  logic [FacW-1:0]        sf_q;
  logic                   gamma_en_q;

  logic accept;
  logic cfg_write;

  // Control shift line that follows each transaction down the lanes
  logic [PipeStages-1:0] vld_q;
  logic [PipeStages-1:0] op_q;
  logic [PixW-1:0]       idx_q [PipeStages];
  logic [PixW-1:0]       tval_q [PipeStages];
  logic                  done_q;

  logic signed [ChW-1:0]   ch_r, ch_g, ch_b;
  logic signed [LumaW-1:0] luma;
  logic [PixW-1:0]         val_r, val_g, val_b;
  gamma_wr_t               gwr;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offm_q     <= OffmReset;
      cf_q       <= FacReset;
      sf_q       <= FacReset;
      gamma_en_q <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CfgBrightness:  offm_q     <= offm_from_setting(cfg_data_i);
        CfgContrast:    cf_q       <= factor_from_setting(cfg_data_i);
        CfgSaturation:  sf_q       <= factor_from_setting(cfg_data_i);
        CfgGammaEnable: gamma_en_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Advance valid and op with every clock; no stall exists on either side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      op_q   <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[PipeStages-2:0], accept};
      op_q   <= {op_q[PipeStages-2:0], op_i};
      done_q <= vld_q[PipeStages-1] & ~op_q[PipeStages-1];
    end
  end

  // Table write payload rides along so it hits the table in program order.
  always_ff @(posedge clk_i) begin
    idx_q[0]  <= table_index_i;
    tval_q[0] <= table_value_i;
    for (int s = 1; s < PipeStages; s++) begin
      idx_q[s]  <= idx_q[s-1];
      tval_q[s] <= tval_q[s-1];
    end
  end

  always_comb begin
    gwr.we   = vld_q[PipeStages-1] & op_q[PipeStages-1];
    gwr.addr = idx_q[PipeStages-1];
    gwr.data = tval_q[PipeStages-1];
  end

  cadj_lane u_lane_r (
    .clk_i  (clk_i),
    .pix_i  (red_in_i),
    .offm_i (offm_q),
    .cf_i   (cf_q),
    .sf_i   (sf_q),
    .luma_i (luma),
    .ch_o   (ch_r),
    .val_o  (val_r)
  );

  cadj_lane u_lane_g (
    .clk_i  (clk_i),
    .pix_i  (green_in_i),
    .offm_i (offm_q),
    .cf_i   (cf_q),
    .sf_i   (sf_q),
    .luma_i (luma),
    .ch_o   (ch_g),
    .val_o  (val_g)
  );

  cadj_lane u_lane_b (
    .clk_i  (clk_i),
    .pix_i  (blue_in_i),
    .offm_i (offm_q),
    .cf_i   (cf_q),
    .sf_i   (sf_q),
    .luma_i (luma),
    .ch_o   (ch_b),
    .val_o  (val_b)
  );

  // Merge the three contrast-adjusted channels into luma.
  cadj_luma u_luma (
    .clk_i  (clk_i),
    .ch_r_i (ch_r),
    .ch_g_i (ch_g),
    .ch_b_i (ch_b),
    .luma_o (luma)
  );

  // One table copy per channel; all three take the same writes.
  cadj_gamma #(.Depth(GAMMA_TABLE_DEPTH)) u_gamma_r (
    .clk_i      (clk_i),
    .wr_i       (gwr),
    .val_i      (val_r),
    .gamma_en_i (gamma_en_q),
    .out_o      (red_out_o)
  );

  cadj_gamma #(.Depth(GAMMA_TABLE_DEPTH)) u_gamma_g (
    .clk_i      (clk_i),
    .wr_i       (gwr),
    .val_i      (val_g),
    .gamma_en_i (gamma_en_q),
    .out_o      (green_out_o)
  );

  cadj_gamma #(.Depth(GAMMA_TABLE_DEPTH)) u_gamma_b (
    .clk_i      (clk_i),
    .wr_i       (gwr),
    .val_i      (val_b),
    .gamma_en_i (gamma_en_q),
    .out_o      (blue_out_o)
  );

  assign done_o = done_q;

endmodule
